FILE: rtl/swarm_phase_fuzzy_classifier_defines.svh
// Assertion macros used by the classifier top level.
`ifndef SWARM_PHASE_FUZZY_CLASSIFIER_DEFINES_SVH
`define SWARM_PHASE_FUZZY_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FW = FRAC_BITS + 1;
	localparam int MW = FRAC_BITS + 6;

	localparam longint ONE_L = longint'(1) << FRAC_BITS;

	localparam logic signed [MW-1:0] ONE_M = MW'(ONE_L);
	localparam logic signed [MW-1:0] C2 = MW'(2 * ONE_L);
	localparam logic signed [MW-1:0] C3 = MW'(3 * ONE_L);
	localparam logic signed [MW-1:0] C4 = MW'(4 * ONE_L);
	localparam logic signed [MW-1:0] C7 = MW'(7 * ONE_L);
	localparam logic signed [MW-1:0] C8 = MW'(8 * ONE_L);
	localparam logic signed [MW-1:0] C3H = MW'((3 * ONE_L) / 2);

	typedef enum logic [2:0] {
		PH_NONE,
		PH_EXPLORE,
		PH_EXPLOIT,
		PH_CONVERGE,
		PH_JUMP
	} phase_t;

	typedef logic [FW-1:0] mem_t;

	typedef struct packed {
		mem_t explore;
		mem_t exploit;
		mem_t converge;
		mem_t jump;
	} mem_set_t;

	typedef struct packed {
		phase_t phase;
		logic   changed;
		logic   fault;
		mem_t   strength;
	} sel_result_t;

	function automatic mem_t clamp_mem(input logic signed [MW-1:0] m);
		mem_t r;
		if (m < 0) begin
			r = '0;
		end else if (m > ONE_M) begin
			r = ONE_M[FW-1:0];
		end else begin
			r = m[FW-1:0];
		end
		return r;
	endfunction

	function automatic mem_t explore_mem(input logic signed [MW-1:0] g);
		logic signed [MW-1:0] g5;
		logic signed [MW-1:0] g10;
		logic signed [MW-1:0] m;
		g5 = (g <<< 2) + g;
		g10 = g5 <<< 1;
		if (g5 <= C2) begin
			m = '0;
		end else if (g5 <= C3) begin
			m = g5 - C2;
		end else if (g10 <= C7) begin
			m = ONE_M;
		end else if (g5 <= C4) begin
			m = C8 - g10;
		end else begin
			m = '0;
		end
		return clamp_mem(m);
	endfunction

	function automatic mem_t converge_mem(input logic signed [MW-1:0] g);
		logic signed [MW-1:0] g5;
		logic signed [MW-1:0] g10;
		logic signed [MW-1:0] m;
		g5 = (g <<< 2) + g;
		g10 = g5 <<< 1;
		if (g10 <= ONE_M) begin
			m = ONE_M;
		end else if (g10 <= C3) begin
			m = C3H - g5;
		end else begin
			m = '0;
		end
		return clamp_mem(m);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sfc_membership.sv
`default_nettype none

module sfc_membership
	import sfc_pkg::*;
(
	input  wire logic [FW-1:0] factor,
	output mem_set_t           mems
);

	logic signed [MW-1:0] f_ext;
	logic signed [MW-1:0] g_ext;

	assign f_ext = signed'({{(MW-FW){1'b0}}, factor});
	assign g_ext = ONE_M - f_ext;

	always_comb begin
		mems.explore = explore_mem(f_ext);
		mems.exploit = explore_mem(g_ext);
		mems.converge = converge_mem(f_ext);
		mems.jump = converge_mem(g_ext);
	end

endmodule

`default_nettype wire

FILE: rtl/sfc_select.sv
`default_nettype none

module sfc_select
	import sfc_pkg::*;
(
	input  wire mem_set_t mems,
	input  wire phase_t   old_phase,
	output sel_result_t   res
);

	logic [3:0] nz;
	logic [2:0] cnt;
	phase_t     c_lo;
	phase_t     c_hi;
	phase_t     hi;
	phase_t     succ;
	phase_t     next_phase;
	logic       fault;

	function automatic mem_t mem_of(input phase_t p, input mem_set_t m);
		mem_t r;
		case (p)
			PH_EXPLORE: r = m.explore;
			PH_EXPLOIT: r = m.exploit;
			PH_CONVERGE: r = m.converge;
			PH_JUMP: r = m.jump;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign nz = {mems.jump != '0, mems.converge != '0, mems.exploit != '0,
		mems.explore != '0};
	assign cnt = 3'($countones(nz));

	always_comb begin
		c_lo = PH_NONE;
		c_hi = PH_NONE;
		for (int i = 3; i >= 0; i--) begin
			if (nz[i]) begin
				c_lo = phase_t'(3'(i + 1));
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (nz[i]) begin
				c_hi = phase_t'(3'(i + 1));
			end
		end
	end

	// Of two equal memberships the larger phase code wins.
	assign hi = (mem_of(c_lo, mems) > mem_of(c_hi, mems)) ? c_lo : c_hi;

	always_comb begin
		case (old_phase)
			PH_EXPLORE: succ = PH_EXPLOIT;
			PH_EXPLOIT: succ = PH_CONVERGE;
			PH_CONVERGE: succ = PH_JUMP;
			PH_JUMP: succ = PH_EXPLORE;
			default: succ = PH_NONE;
		endcase
	end

	always_comb begin
		fault = 1'b0;
		next_phase = old_phase;
		if (cnt == 3'd0 || cnt > 3'd2) begin
			fault = 1'b1;
		end else if (cnt == 3'd1) begin
			next_phase = c_lo;
		end else if (old_phase == PH_NONE) begin
			next_phase = hi;
		end else if (old_phase == c_lo || old_phase == c_hi) begin
			next_phase = old_phase;
		end else if (succ != PH_NONE && (succ == c_lo || succ == c_hi)) begin
			next_phase = succ;
		end else begin
			next_phase = hi;
		end
	end

	always_comb begin
		res.phase = next_phase;
		res.changed = (next_phase != old_phase);
		res.fault = fault;
		res.strength = mem_of(next_phase, mems);
	end

endmodule

`default_nettype wire

FILE: rtl/swarm_phase_fuzzy_classifier.sv
// Classifies each evolutionary factor (unsigned Q1.16) into a swarm phase and
// reports the phase, whether it changed, a fault flag and the membership
// strength of the reported phase. One factor request is accepted every clock
// cycle unless factor_stall is high: the factor is registered, the four
// memberships and the phase selection are computed combinationally against the
// stored phase, and the result is registered and held on the outputs. The rate
// of one request per cycle is set by the stored phase, which is read and
// rewritten in the same cycle. A result that waits on result_stall holds the
// output register while one more request can still be taken.
`default_nettype none

`include "swarm_phase_fuzzy_classifier_defines.svh"

module swarm_phase_fuzzy_classifier
	import sfc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          factor_valid,
	output logic               factor_stall,
	input  wire logic [FW-1:0] factor_q,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [2:0]         phase,
	output logic               changed,
	output logic               fault,
	output logic [FW-1:0]      strength
);

	logic [FW-1:0] factor_s1;
	logic          valid_s1;
	sel_result_t   result_s2;
	logic          valid_s2;
	phase_t        phase_q;
	mem_set_t      mems;
	sel_result_t   sel;
	logic          advance;

	assign advance = valid_s1 && (!valid_s2 || !result_stall);
	assign factor_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!factor_stall) begin
			valid_s1 <= factor_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (factor_valid && !factor_stall) begin
			factor_s1 <= factor_q;
		end
	end

	sfc_membership u_membership (
		.factor (factor_s1),
		.mems   (mems)
	);

	sfc_select u_select (
		.mems      (mems),
		.old_phase (phase_q),
		.res       (sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q <= PH_NONE;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				phase_q <= sel.phase;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= sel;
		end
	end

	assign result_valid = valid_s2;
	assign phase = result_s2.phase;
	assign changed = result_s2.changed;
	assign fault = result_s2.fault;
	assign strength = result_s2.strength;

	`SFC_ASSERT_NOW(a_fault_keeps_phase, valid_s2 && result_s2.fault, !result_s2.changed,
		"fault reported together with a phase change")
	`SFC_ASSERT_NOW(a_none_no_strength, valid_s2 && result_s2.phase == PH_NONE,
		result_s2.strength == '0, "phase none reported with nonzero strength")
	`SFC_ASSERT_NOW(a_state_matches_out, valid_s2, result_s2.phase == phase_q,
		"stored phase differs from the last reported phase")
	`SFC_ASSERT_NEXT(a_stall_means_full, factor_stall, valid_s1,
		"request stalled while the input stage was empty")

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sfc_pkg::*;

	localparam longint UNIT = longint'(1) << FRAC_BITS;
	localparam int STUCK_LIMIT = 1000;
	localparam int RANDOM_REQUESTS = 600;

	typedef struct {
		logic [FW-1:0] value;
		bit            drain;
	} factor_req_t;

	typedef struct {
		phase_t        phase;
		logic          changed;
		logic          fault;
		logic [FW-1:0] strength;
	} phase_report_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          factor_valid = 1'b0;
	logic          factor_stall;
	logic [FW-1:0] factor_q = '0;
	logic          result_valid;
	logic          result_stall = 1'b0;
	logic [2:0]    phase;
	logic          changed;
	logic          fault;
	logic [FW-1:0] strength;

	factor_req_t   pending_factors[$];
	phase_report_t expected_reports[$];
	phase_t        tracked_phase = PH_NONE;
	int            requests_taken = 0;
	int            results_seen = 0;
	int            mismatches = 0;
	int            phase_changes = 0;
	int            faults_seen = 0;
	int            directed_count = 0;
	int            cycle_count = 0;
	int            stuck_cycles = 0;
	longint        walk = 0;
	wire           quiet = (cycle_count >= 300) && (cycle_count < 450);

	swarm_phase_fuzzy_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.factor_valid(factor_valid),
		.factor_stall(factor_stall),
		.factor_q(factor_q),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.phase(phase),
		.changed(changed),
		.fault(fault),
		.strength(strength)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint explore_shape(input longint g);
		if (5 * g <= 2 * UNIT) return 0;
		if (5 * g <= 3 * UNIT) return 5 * g - 2 * UNIT;
		if (10 * g <= 7 * UNIT) return UNIT;
		if (5 * g <= 4 * UNIT) return 8 * UNIT - 10 * g;
		return 0;
	endfunction

	function automatic longint converge_shape(input longint g);
		if (10 * g <= UNIT) return UNIT;
		if (10 * g <= 3 * UNIT) return (3 * UNIT) / 2 - 5 * g;
		return 0;
	endfunction

	function automatic longint clamp_unit(input longint m);
		if (m < 0) return 0;
		if (m > UNIT) return UNIT;
		return m;
	endfunction

	function automatic phase_report_t classify_factor(input logic [FW-1:0] f_q,
			input phase_t prior);
		longint        f;
		longint        g;
		longint        m [5];
		phase_t        cands [2];
		int            n;
		phase_t        hi;
		phase_t        succ;
		phase_t        nxt;
		phase_report_t r;
		f = longint'(f_q);
		g = UNIT - f;
		m[0] = 0;
		m[1] = clamp_unit(explore_shape(f));
		m[2] = clamp_unit(explore_shape(g));
		m[3] = clamp_unit(converge_shape(f));
		m[4] = clamp_unit(converge_shape(g));
		n = 0;
		cands[0] = PH_NONE;
		cands[1] = PH_NONE;
		for (int i = 1; i <= 4; i++) begin
			if (m[i] != 0) begin
				if (n < 2) cands[n] = phase_t'(i);
				n++;
			end
		end
		nxt = prior;
		r.fault = 1'b0;
		if (n == 0 || n > 2) begin
			r.fault = 1'b1;
		end else if (n == 1) begin
			nxt = cands[0];
		end else begin
			hi = (m[cands[0]] > m[cands[1]]) ? cands[0] : cands[1];
			case (prior)
				PH_EXPLORE: succ = PH_EXPLOIT;
				PH_EXPLOIT: succ = PH_CONVERGE;
				PH_CONVERGE: succ = PH_JUMP;
				PH_JUMP: succ = PH_EXPLORE;
				default: succ = PH_NONE;
			endcase
			if (prior == PH_NONE) begin
				nxt = hi;
			end else if (prior == cands[0] || prior == cands[1]) begin
				nxt = prior;
			end else if (succ != PH_NONE && (succ == cands[0] || succ == cands[1])) begin
				nxt = succ;
			end else begin
				nxt = hi;
			end
		end
		r.phase = nxt;
		r.changed = (nxt != prior);
		r.strength = (nxt == PH_NONE) ? '0 : FW'(m[nxt]);
		return r;
	endfunction

	task automatic queue_factor(input longint v, input bit drain);
		factor_req_t req;
		if (v < 0) v = 0;
		if (v > (2 * UNIT - 1)) v = 2 * UNIT - 1;
		req.value = FW'(v);
		req.drain = drain;
		pending_factors.insert(pending_factors.size(), req);
	endtask

	task automatic log_mismatch(input string msg);
		if (mismatches < 10) $display("%s", msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		phase_report_t report;
		factor_req_t   req;
		if (!arst_n) begin
			factor_valid <= 1'b0;
			factor_q <= '0;
			requests_taken <= 0;
			tracked_phase = PH_NONE;
		end else begin
			if (factor_valid && !factor_stall) begin
				report = classify_factor(factor_q, tracked_phase);
				tracked_phase = report.phase;
				expected_reports.insert(expected_reports.size(), report);
				requests_taken <= requests_taken + 1;
			end
			if (!(factor_valid && factor_stall)) begin
				if (pending_factors.size() > 0
						&& !(pending_factors[0].drain
							&& (factor_valid || requests_taken != results_seen))
						&& (quiet || $urandom_range(0, 99) >= 8)) begin
					req = pending_factors.pop_front();
					factor_valid <= 1'b1;
					factor_q <= req.value;
				end else begin
					factor_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		phase_report_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			results_seen <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (changed) phase_changes++;
				if (fault) faults_seen++;
				if (expected_reports.size() == 0) begin
					log_mismatch($sformatf({"Unexpected result: phase %0d changed %0d ",
						"fault %0d strength %0d"}, phase, changed, fault, strength));
				end else begin
					want = expected_reports.pop_front();
					if (phase !== want.phase || changed !== want.changed
							|| fault !== want.fault || strength !== want.strength) begin
						log_mismatch($sformatf({"Mismatch: expected phase %0d changed %0d fault %0d ",
							"strength %0d, got phase %0d changed %0d fault %0d strength %0d"},
							want.phase, want.changed, want.fault, want.strength,
							phase, changed, fault, strength));
					end
				end
			end
			result_stall <= !quiet && ($urandom_range(0, 99) < 8);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
			stuck_cycles <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if ((factor_valid && !factor_stall) || (result_valid && !result_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		longint edges [8];
		int     pick;
		edges = '{6554, 13107, 19661, 26214, 39322, 45875, 52429, 58982};

		queue_factor(0, 0);
		queue_factor(6553, 0);
		queue_factor(6554, 0);
		queue_factor(13107, 0);
		queue_factor(19660, 0);
		queue_factor(19661, 0);
		queue_factor(26214, 0);
		queue_factor(26215, 0);
		queue_factor(32768, 0);
		queue_factor(39321, 0);
		queue_factor(39322, 0);
		queue_factor(45875, 0);
		queue_factor(45876, 0);
		queue_factor(52428, 0);
		queue_factor(52429, 0);
		queue_factor(58982, 0);
		queue_factor(58983, 0);
		queue_factor(42598, 0);
		queue_factor(16384, 0);
		queue_factor(20000, 0);
		queue_factor(65536, 0);
		queue_factor(65537, 0);
		queue_factor(131071, 0);
		queue_factor(12000, 0);
		directed_count = pending_factors.size();

		walk = UNIT / 2;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				walk = $urandom_range(0, 65536);
			end else if (pick < 78) begin
				walk = edges[$urandom_range(0, 7)] + longint'($urandom_range(0, 128)) - 64;
			end else if (pick < 90) begin
				walk = walk + longint'($urandom_range(0, 4096)) - 2048;
			end else begin
				walk = $urandom_range(0, 131071);
			end
			queue_factor(walk, (i == 0) || (i == 300));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (pending_factors.size() != 0 || factor_valid || requests_taken != results_seen);
		repeat (8) @(negedge clk);

		$display("Checked %0d factor requests (%0d directed) against the phase predictor,",
			requests_taken, directed_count);
		$display("seeing %0d phase changes and %0d faults.", phase_changes, faults_seen);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
